[rtl/kts_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package kts_pkg;

  // Table geometry.
  localparam int unsigned TableDepth = 32;
  localparam int unsigned KeyBits    = 32;
  localparam int unsigned ValueBits  = 32;
  localparam int unsigned IdxBits    = $clog2(TableDepth);
  localparam int unsigned CountBits  = $clog2(TableDepth + 1);
  localparam int unsigned EntryBits  = KeyBits + ValueBits;

  // Action codes carried by a request.
  localparam logic [2:0] ActClear  = 3'd0;
  localparam logic [2:0] ActInsert = 3'd1;
  localparam logic [2:0] ActErase  = 3'd2;
  localparam logic [2:0] ActLookup = 3'd3;
  localparam logic [2:0] ActCount  = 3'd4;

  // Status codes returned with every result.
  localparam logic [1:0] StatOk     = 2'd0;
  localparam logic [1:0] StatAbsent = 2'd1;
  localparam logic [1:0] StatDup    = 2'd2;
  localparam logic [1:0] StatFull   = 2'd3;

  typedef struct packed {
    logic [2:0]           action;
    logic [KeyBits-1:0]   item_key;
    logic [ValueBits-1:0] item_value;
  } req_t;

  typedef struct packed {
    logic [1:0]           status;
    logic                 found;
    logic [ValueBits-1:0] read_value;
    logic [CountBits-1:0] match_count;
    logic [CountBits-1:0] occupancy;
  } rsp_t;

endpackage

`default_nettype wire

[rtl/keyed_table_store_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                  Payload
// request   in         in_valid_i / in_ready_o    in_req_i  (kts_pkg::req_t)
// result    out        out_valid_o / out_ready_i  out_rsp_o (kts_pkg::rsp_t)
//
// One request is in flight at a time. An erase that hits an entry other than the last moves
// the last entry into the freed slot; a key hit ends the scan early. Each request is served by
// a linear scan over the entry memory, with one read issued per cycle.
// Clear and unused actions skip the scan. Reset empties the table at once; no clearing pass.
// The result register lets the next request enter while a result waits to be taken.
module keyed_table_store_top (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire kts_pkg::req_t  in_req_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output kts_pkg::rsp_t       out_rsp_o
);

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StScan = 4'b0010,
    StMove = 4'b0100,
    StDone = 4'b1000
  } state_e;

  state_e                          state_q, state_d;
  kts_pkg::req_t                   req_q, req_d;
  kts_pkg::rsp_t                   res_q, res_d;
  kts_pkg::rsp_t                   out_q, out_d;
  logic                            out_valid_q, out_valid_d;
  logic [kts_pkg::CountBits-1:0]   count_q, count_d;
  logic [kts_pkg::CountBits-1:0]   issue_q, issue_d;
  logic [kts_pkg::CountBits-1:0]   last_cnt;
  logic                            rd_pend_q, rd_pend_d;
  logic [kts_pkg::IdxBits-1:0]     rd_idx_q, rd_idx_d;
  logic [kts_pkg::IdxBits-1:0]     slot_q, slot_d;

  // Entry memory: key in the upper half, value in the lower half.
  logic [kts_pkg::EntryBits-1:0]   mem_q [kts_pkg::TableDepth];
  logic [kts_pkg::EntryBits-1:0]   mem_rdata_q;
  logic                            mem_re, mem_we;
  logic [kts_pkg::IdxBits-1:0]     mem_raddr, mem_waddr;
  logic [kts_pkg::EntryBits-1:0]   mem_wdata;

  logic [kts_pkg::KeyBits-1:0]     rd_key;
  logic [kts_pkg::ValueBits-1:0]   rd_val;
  logic                            more, key_hit, val_hit;

  assign rd_key   = mem_rdata_q[kts_pkg::EntryBits-1:kts_pkg::ValueBits];
  assign rd_val   = mem_rdata_q[kts_pkg::ValueBits-1:0];
  assign last_cnt = kts_pkg::CountBits'(count_q - 1'b1);

  // Scan compare on the entry read in the previous cycle.
  assign more    = (issue_q < count_q);
  assign key_hit = rd_pend_q && (req_q.action != kts_pkg::ActCount) &&
                   (rd_key == req_q.item_key);
  assign val_hit = rd_pend_q && (req_q.action == kts_pkg::ActCount) &&
                   (rd_val == req_q.item_value);

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // Sequencer: accept, scan (skipped for clear and unused actions), optional move, hand off the result.
  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    count_d     = count_q;
    issue_d     = issue_q;
    rd_pend_d   = 1'b0;
    rd_idx_d    = rd_idx_q;
    slot_d      = slot_q;
    mem_re      = 1'b0;
    mem_raddr   = issue_q[kts_pkg::IdxBits-1:0];
    mem_we      = 1'b0;
    mem_waddr   = count_q[kts_pkg::IdxBits-1:0];
    mem_wdata   = {req_q.item_key, req_q.item_value};

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          req_d   = in_req_i;
          res_d   = '0;
          issue_d = '0;
          priority if (in_req_i.action == kts_pkg::ActClear) begin
            count_d = '0;
            state_d = StDone;
          end else if (in_req_i.action == kts_pkg::ActInsert ||
                       in_req_i.action == kts_pkg::ActErase  ||
                       in_req_i.action == kts_pkg::ActLookup ||
                       in_req_i.action == kts_pkg::ActCount) begin
            state_d = StScan;
          end else begin
            state_d = StDone;
          end
        end
      end

      StScan: begin
        if (val_hit) begin
          res_d.match_count = kts_pkg::CountBits'(res_q.match_count + 1'b1);
        end
        // Issue the next read unless the key was just found.
        if (more && !key_hit) begin
          mem_re    = 1'b1;
          mem_raddr = issue_q[kts_pkg::IdxBits-1:0];
          rd_pend_d = 1'b1;
          rd_idx_d  = issue_q[kts_pkg::IdxBits-1:0];
          issue_d   = kts_pkg::CountBits'(issue_q + 1'b1);
        end
        // Scan ends on a key hit or once the last entry has been compared.
        if (key_hit || !more) begin
          res_d.found = key_hit;
          state_d     = StDone;
          priority if (req_q.action == kts_pkg::ActInsert) begin
            priority if (count_q == kts_pkg::CountBits'(kts_pkg::TableDepth)) begin
              res_d.status = kts_pkg::StatFull;
            end else if (key_hit) begin
              res_d.status = kts_pkg::StatDup;
            end else begin
              mem_we  = 1'b1;
              count_d = kts_pkg::CountBits'(count_q + 1'b1);
            end
          end else if (req_q.action == kts_pkg::ActErase) begin
            if (key_hit) begin
              if (rd_idx_q == last_cnt[kts_pkg::IdxBits-1:0]) begin
                count_d = last_cnt;
              end else begin
                // Fetch the last entry to fill the gap.
                mem_re    = 1'b1;
                mem_raddr = last_cnt[kts_pkg::IdxBits-1:0];
                slot_d    = rd_idx_q;
                state_d   = StMove;
              end
            end else begin
              res_d.status = kts_pkg::StatAbsent;
            end
          end else if (req_q.action == kts_pkg::ActLookup) begin
            if (key_hit) begin
              res_d.read_value = rd_val;
            end else begin
              res_d.status = kts_pkg::StatAbsent;
            end
          end else begin
            res_d.found = 1'b0;
          end
        end
      end

      StMove: begin
        mem_we    = 1'b1;
        mem_waddr = slot_q;
        mem_wdata = mem_rdata_q;
        count_d   = last_cnt;
        state_d   = StDone;
      end

      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          out_d           = res_q;
          out_d.occupancy = count_q;
          out_valid_d     = 1'b1;
          state_d         = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      rd_pend_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      rd_pend_q   <= rd_pend_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    res_q    <= res_d;
    out_q    <= out_d;
    issue_q  <= issue_d;
    rd_idx_q <= rd_idx_d;
    slot_q   <= slot_d;
  end

  // Entry memory write port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
  end

  // Entry memory read port with registered data.
  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      mem_rdata_q <= mem_q[mem_raddr];
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= kts_pkg::CountBits'(kts_pkg::TableDepth))
    else $error("occupancy beyond table depth");

  a_pend_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> (state_q == StScan))
    else $error("scan read pending outside scan");

  a_move_from_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StMove) |-> ($past(state_q) == StScan))
    else $error("move entered without scan");

  a_move_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StMove) |=> (count_q == kts_pkg::CountBits'($past(count_q) - 1'b1)))
    else $error("erase move did not shrink the table");

  a_write_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && state_q == StScan) |-> (count_q < kts_pkg::CountBits'(kts_pkg::TableDepth)))
    else $error("insert write into a full table");
`endif

endmodule

`default_nettype wire
